// File: rtl/scpa_pkg.sv
package scpa_pkg;

  // Heap geometry. The address fields are 16 bits wide, so the geometry is fixed.
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned CHUNK_LOG     = 12;
  localparam int unsigned CHUNK_BYTES   = 1 << CHUNK_LOG;
  localparam int unsigned MIN_BLOCK_LOG = 5;
  localparam int unsigned NUM_CLASSES   = 8;
  localparam int unsigned HDR_BYTES     = 8;

  // Derived widths.
  localparam int unsigned CLS_W   = $clog2(NUM_CLASSES);
  localparam int unsigned BP_W    = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned GRAN_AW = ADDR_W - MIN_BLOCK_LOG;
  localparam int unsigned CNT_W   = CHUNK_LOG - MIN_BLOCK_LOG;

  // Action codes on the input word.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NULL      = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_EXHAUSTED = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_FIN
  } state_e;

  // Operation chosen when a word is accepted.
  typedef enum logic [1:0] {
    OP_REJECT,
    OP_POP,
    OP_REFILL,
    OP_FREE
  } op_e;

  // Port of the link memory.
  typedef struct packed {
    logic               re;
    logic [GRAN_AW-1:0] raddr;
    logic               we;
    logic [GRAN_AW-1:0] waddr;
    logic [ADDR_W-1:0]  wdata;
  } link_port_t;

  // Port of the class tag memory.
  typedef struct packed {
    logic               re;
    logic [GRAN_AW-1:0] raddr;
    logic               we;
    logic [GRAN_AW-1:0] waddr;
    logic [CLS_W-1:0]   wdata;
  } tag_port_t;

endpackage

// File: rtl/scpa_ram.sv
module scpa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/scpa_ctrl.sv
module scpa_ctrl
  import scpa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [ADDR_W-1:0]   request_size_i,
  input  logic [ADDR_W-1:0]   free_address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ADDR_W-1:0]   address_o,
  output logic [1:0]          status_o,
  output link_port_t          link_port_o,
  input  logic [ADDR_W-1:0]   link_rdata_i,
  output tag_port_t           tag_port_o,
  input  logic [CLS_W-1:0]    tag_rdata_i
);

  // Class of a request: bit length of (size + 7) above the smallest block size.
  function automatic logic [CLS_W-1:0] class_of(logic [CNT_W-1:0] v);
    logic [CLS_W-1:0] n;
    n = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) begin
        n = CLS_W'(i + 1);
      end
    end
    return n;
  endfunction

  // Offset mask of a block within its chunk (block size minus one).
  function automatic logic [CHUNK_LOG-1:0] block_mask(logic [CLS_W-1:0] c);
    logic [CHUNK_LOG-1:0] m;
    for (int i = 0; i < CHUNK_LOG; i++) begin
      m[i] = (i < (int'(c) + MIN_BLOCK_LOG));
    end
    return m;
  endfunction

  state_e                  state_q, state_d;
  op_e                     op_q, op_d;
  logic [CLS_W-1:0]        cls_q, cls_d;
  logic [ADDR_W-1:0]       blk_q, blk_d;
  status_e                 rej_q, rej_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [BP_W-1:0]         bp_q, bp_d;
  logic [ADDR_W-1:0]       heads_q [NUM_CLASSES];
  logic [ADDR_W-1:0]       heads_d [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]  nonempty_q, nonempty_d;
  logic                    out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]       address_q;
  status_e                 status_q;

  logic                    acc;
  logic                    out_free;
  logic                    out_load;
  logic [ADDR_W-1:0]       out_addr;
  status_e                 out_status;
  logic [CHUNK_LOG-1:0]    size_sum;
  logic [CLS_W-1:0]        in_cls;
  logic [ADDR_W-1:0]       blk_in;
  logic [CHUNK_LOG-1:0]    free_mask;
  logic [CHUNK_LOG-1:0]    cls_mask;
  logic [ADDR_W-1:0]       cls_bytes;
  logic [ADDR_W-CHUNK_LOG-1:0] chunk_sel;
  logic [ADDR_W-1:0]       fill_blk;
  logic [ADDR_W-1:0]       last_blk;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Decode of the incoming word.
  assign size_sum = request_size_i[CHUNK_LOG-1:0] + CHUNK_LOG'(HDR_BYTES - 1);
  assign in_cls   = class_of(size_sum[CHUNK_LOG-1:MIN_BLOCK_LOG]);
  assign blk_in   = free_address_i - ADDR_W'(HDR_BYTES);

  // Geometry of the class in work and of the carved chunk.
  assign free_mask = block_mask(tag_rdata_i);
  assign cls_mask  = block_mask(cls_q);
  assign cls_bytes = ADDR_W'(cls_mask) + ADDR_W'(1);
  assign chunk_sel = bp_q[ADDR_W-1:CHUNK_LOG];
  assign fill_blk  = {chunk_sel, cnt_q, MIN_BLOCK_LOG'(0)};
  assign last_blk  = {chunk_sel, CHUNK_LOG'(0)} + ADDR_W'(CHUNK_BYTES) - cls_bytes;

  // Next state, list updates and memory requests.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cls_d       = cls_q;
    blk_d       = blk_q;
    rej_d       = rej_q;
    cnt_d       = cnt_q;
    bp_d        = bp_q;
    heads_d     = heads_q;
    nonempty_d  = nonempty_q;
    out_load    = 1'b0;
    out_addr    = '0;
    out_status  = STATUS_OK;

    // Both memories are read at accept; the data is used in the next cycle, in S_EXEC.
    link_port_o.re    = acc;
    link_port_o.raddr = heads_q[in_cls][ADDR_W-1:MIN_BLOCK_LOG];
    link_port_o.we    = 1'b0;
    link_port_o.waddr = blk_q[ADDR_W-1:MIN_BLOCK_LOG];
    link_port_o.wdata = '0;
    tag_port_o.re     = acc;
    tag_port_o.raddr  = blk_in[ADDR_W-1:MIN_BLOCK_LOG];
    tag_port_o.we     = 1'b0;
    tag_port_o.waddr  = {chunk_sel, cnt_q};
    tag_port_o.wdata  = cls_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = S_EXEC;
          cls_d   = in_cls;
          blk_d   = blk_in;
          rej_d   = STATUS_NULL;
          if (action_i == ACT_FREE) begin
            if (free_address_i < ADDR_W'(HDR_BYTES) || {1'b0, blk_in} >= bp_q) begin
              op_d = OP_REJECT;
            end else begin
              op_d = OP_FREE;
            end
          end else if (request_size_i == '0) begin
            op_d = OP_REJECT;
          end else if (request_size_i > ADDR_W'(CHUNK_BYTES - HDR_BYTES)) begin
            op_d  = OP_REJECT;
            rej_d = STATUS_TOO_LARGE;
          end else if (nonempty_q[in_cls]) begin
            op_d = OP_POP;
          end else if (bp_q > BP_W'(HEAP_BYTES - CHUNK_BYTES)) begin
            op_d  = OP_REJECT;
            rej_d = STATUS_EXHAUSTED;
          end else begin
            op_d = OP_REFILL;
          end
        end
      end

      S_EXEC: begin
        if (op_q == OP_REFILL) begin
          state_d = S_FILL;
          cnt_d   = '0;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          case (op_q)
            OP_POP: begin
              // Unlink the head; the stored link is a payload address.
              out_addr = heads_q[cls_q] + ADDR_W'(HDR_BYTES);
              if (link_rdata_i == '0) begin
                nonempty_d[cls_q] = 1'b0;
                heads_d[cls_q]    = '0;
              end else begin
                heads_d[cls_q] = link_rdata_i - ADDR_W'(HDR_BYTES);
              end
            end
            OP_FREE: begin
              // A block must start on a boundary of its chunk's class.
              if ((blk_q[CHUNK_LOG-1:0] & free_mask) != '0) begin
                out_status = STATUS_NULL;
              end else begin
                link_port_o.we          = 1'b1;
                link_port_o.wdata       = nonempty_q[tag_rdata_i] ?
                                          heads_q[tag_rdata_i] + ADDR_W'(HDR_BYTES) : '0;
                heads_d[tag_rdata_i]    = blk_q;
                nonempty_d[tag_rdata_i] = 1'b1;
              end
            end
            default: begin
              out_status = rej_q;
            end
          endcase
        end
      end

      S_FILL: begin
        // One granule a cycle: tag every granule, link every block start.
        tag_port_o.we     = 1'b1;
        link_port_o.we    = ((cnt_q & cls_mask[CHUNK_LOG-1:MIN_BLOCK_LOG]) == '0);
        link_port_o.waddr = {chunk_sel, cnt_q};
        link_port_o.wdata = (cnt_q == '0) ? '0 :
                            fill_blk - cls_bytes + ADDR_W'(HDR_BYTES);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == '1) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_addr = last_blk + ADDR_W'(HDR_BYTES);
          if (cls_q != CLS_W'(NUM_CLASSES - 1)) begin
            heads_d[cls_q]    = last_blk - cls_bytes;
            nonempty_d[cls_q] = 1'b1;
          end
          bp_d    = bp_q + BP_W'(CHUNK_BYTES);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_REJECT;
      cnt_q       <= '0;
      bp_q        <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      bp_q        <= bp_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
    blk_q <= blk_d;
    rej_q <= rej_d;
    if (out_load) begin
      address_q <= out_addr;
      status_q  <= out_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign status_o    = status_q;

  // An accepted word always enters execution next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == S_EXEC)
    else $error("accepted word did not enter execution");

  // A waiting result is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_load && out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  // The break pointer stays chunk aligned and inside the heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q[CHUNK_LOG-1:0] == '0 && bp_q <= BP_W'(HEAP_BYTES))
    else $error("break pointer out of range");

  // The fill counter rests at zero outside the chunk walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_FILL |-> cnt_q == '0)
    else $error("fill counter not at rest");

endmodule

// File: rtl/size_class_pool_allocator_core.sv
// A pop, free or reject goes from accept through S_EXEC into the result register;
// an allocate that carves a new chunk goes through S_EXEC, S_FILL (one granule tag
// per cycle) and S_FIN. The input is stalled while the sequencer is not idle: no new
// word is taken until the last one has loaded its result, a chunk carve included.
// Reset clears the free lists and the break pointer at once; the link and tag memories
// are not cleared, since every entry is written before it is read.
module size_class_pool_allocator_core
  import scpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [ADDR_W-1:0] request_size_i,
  input  logic [ADDR_W-1:0] free_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] address_o,
  output logic [1:0]        status_o
);

  link_port_t         link_port;
  tag_port_t          tag_port;
  logic [ADDR_W-1:0]  link_rdata;
  logic [CLS_W-1:0]   tag_rdata;

  // Sequencer with list heads, break pointer and result register.
  scpa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .address_o      (address_o),
    .status_o       (status_o),
    .link_port_o    (link_port),
    .link_rdata_i   (link_rdata),
    .tag_port_o     (tag_port),
    .tag_rdata_i    (tag_rdata)
  );

  // Next-block links, one entry per granule.
  scpa_ram #(
    .Width (ADDR_W),
    .Depth (1 << GRAN_AW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_port.we),
    .waddr_i (link_port.waddr),
    .wdata_i (link_port.wdata),
    .re_i    (link_port.re),
    .raddr_i (link_port.raddr),
    .rdata_o (link_rdata)
  );

  // Size class of the chunk that holds each granule.
  scpa_ram #(
    .Width (CLS_W),
    .Depth (1 << GRAN_AW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_port.we),
    .waddr_i (tag_port.waddr),
    .wdata_i (tag_port.wdata),
    .re_i    (tag_port.re),
    .raddr_i (tag_port.raddr),
    .rdata_o (tag_rdata)
  );

endmodule
